// ===== hw/rtl/gbs_pkg.sv =====
// ----------------------------------------------------------------------------
// gbs_pkg: shared types and constants of the grid search stepper
// Grid geometry, cell word layout, codes and the control/status structs.
// ----------------------------------------------------------------------------
package gbs_pkg;

   localparam int ROW_W   = 5;
   localparam int COL_W   = 6;
   localparam int CELL_W  = ROW_W + COL_W;
   localparam int CELLS   = 1 << CELL_W;
   localparam int CNT_W   = CELL_W + 1;
   localparam int WORD_W  = 6;
   localparam int CSR_W   = 6;

   localparam logic [ROW_W-1:0] ROW_MAX = {ROW_W{1'b1}};
   localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};

   // cell word: obstacle, visited, frontier, parent direction
   localparam int BIT_OBST = 5;
   localparam int BIT_VIS  = 4;
   localparam int BIT_FRO  = 3;

   localparam logic [2:0] DIR_NONE  = 3'd0;
   localparam logic [2:0] DIR_LEFT  = 3'd1;
   localparam logic [2:0] DIR_RIGHT = 3'd2;
   localparam logic [2:0] DIR_UP    = 3'd3;
   localparam logic [2:0] DIR_DOWN  = 3'd4;

   localparam logic [1:0] ACT_TOGGLE = 2'd0;
   localparam logic [1:0] ACT_CLEAR  = 2'd1;
   localparam logic [1:0] ACT_EXPAND = 2'd2;
   localparam logic [1:0] ACT_QUERY  = 2'd3;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_SOLVED  = 2'd1;
   localparam logic [1:0] ST_EMPTY   = 2'd2;

   localparam logic [1:0] CSR_START_ROW = 2'd0;
   localparam logic [1:0] CSR_START_COL = 2'd1;
   localparam logic [1:0] CSR_END_ROW   = 2'd2;
   localparam logic [1:0] CSR_END_COL   = 2'd3;

   typedef enum logic [2:0] {
      SEL_PORT, SEL_REQ, SEL_START, SEL_QDATA, SEL_POP, SEL_NBR, SEL_SWEEP
   } sel_type;

   typedef enum logic [2:0] {
      WR_NONE, WR_TOGGLE, WR_SEED, WR_UNFRONT, WR_VISIT, WR_ZERO
   } wr_type;

   typedef enum logic [1:0] {
      KIND_ZERO, KIND_REQ, KIND_POP
   } kind_type;

   typedef struct packed {
      logic       load_req;
      logic       cell_rd;
      sel_type    sel;
      wr_type     wr;
      logic       cap_req_bits;
      logic       cap_pop_bits;
      logic       wipe;
      logic       seed;
      logic       q_rd;
      logic       pop;
      logic       push_nbr;
      logic       nbr_clr;
      logic       nbr_inc;
      logic       sweep_clr;
      logic       sweep_inc;
      logic       rsp_load;
      kind_type   rsp_kind;
      logic [1:0] rsp_status;
   } cmd_type;

   typedef struct packed {
      logic solved;
      logic seeded;
      logic fill_zero;
      logic sweep_last;
      logic nbr_ok;
      logic nbr_last;
      logic nbr_free;
      logic rsp_busy;
   } stat_type;

endpackage

// ===== hw/rtl/gbs_ram.sv =====
// ----------------------------------------------------------------------------
// gbs_ram: generic memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/gbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbs_ctrl: sequencer of the grid search stepper
// Walks each item through cell and queue memory accesses.
// ----------------------------------------------------------------------------
module gbs_ctrl import gbs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_action,
   output logic       req_stall,
   input  stat_type   stat,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_CELL, S_SEED, S_POP_RD, S_POP_Q, S_POP_CELL,
      S_NBR_RD, S_NBR_WR, S_CLR, S_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] act_ff, act_in;
   logic [1:0] status_ff, status_in;
   kind_type   kind_ff, kind_in;

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      status_in = status_ff;
      kind_in   = kind_ff;
      cmd       = '0;
      cmd.sel   = SEL_PORT;
      cmd.wr    = WR_NONE;
      cmd.rsp_kind   = kind_ff;
      cmd.rsp_status = status_ff;
      case (state_ff)
         S_INIT: begin
            cmd.sel = SEL_SWEEP;
            cmd.wr  = WR_ZERO;
            cmd.sweep_inc = 1'b1;
            if (stat.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               act_in = req_action;
               status_in = ST_DONE;
               case (req_action)
                  ACT_CLEAR: begin
                     cmd.wipe = 1'b1;
                     cmd.sweep_clr = 1'b1;
                     kind_in = KIND_ZERO;
                     state_in = S_CLR;
                  end
                  ACT_EXPAND: begin
                     kind_in = KIND_ZERO;
                     if (stat.solved) begin
                        status_in = ST_SOLVED;
                        state_in = S_OUT;
                     end else if (!stat.seeded) begin
                        cmd.cell_rd = 1'b1;
                        cmd.sel = SEL_START;
                        state_in = S_SEED;
                     end else begin
                        state_in = S_POP_RD;
                     end
                  end
                  default: begin
                     cmd.cell_rd = 1'b1;
                     cmd.sel = SEL_PORT;
                     kind_in = KIND_REQ;
                     state_in = S_CELL;
                  end
               endcase
            end
         end
         S_CELL: begin
            cmd.sel = SEL_REQ;
            cmd.cap_req_bits = 1'b1;
            if (act_ff == ACT_TOGGLE) begin
               if (stat.solved) status_in = ST_SOLVED;
               else cmd.wr = WR_TOGGLE;
            end
            state_in = S_OUT;
         end
         S_SEED: begin
            cmd.sel = SEL_START;
            cmd.wr = WR_SEED;
            cmd.seed = 1'b1;
            state_in = S_POP_RD;
         end
         S_POP_RD: begin
            if (stat.fill_zero) begin
               status_in = ST_EMPTY;
               state_in = S_OUT;
            end else begin
               cmd.q_rd = 1'b1;
               state_in = S_POP_Q;
            end
         end
         S_POP_Q: begin
            cmd.sel = SEL_QDATA;
            cmd.cell_rd = 1'b1;
            cmd.pop = 1'b1;
            state_in = S_POP_CELL;
         end
         S_POP_CELL: begin
            cmd.sel = SEL_POP;
            cmd.wr = WR_UNFRONT;
            cmd.cap_pop_bits = 1'b1;
            cmd.nbr_clr = 1'b1;
            kind_in = KIND_POP;
            state_in = S_NBR_RD;
         end
         S_NBR_RD: begin
            cmd.sel = SEL_NBR;
            if (stat.nbr_ok) begin
               cmd.cell_rd = 1'b1;
               state_in = S_NBR_WR;
            end else if (stat.nbr_last) begin
               state_in = S_OUT;
            end else begin
               cmd.nbr_inc = 1'b1;
            end
         end
         S_NBR_WR: begin
            cmd.sel = SEL_NBR;
            if (stat.nbr_free) begin
               cmd.wr = WR_VISIT;
               cmd.push_nbr = 1'b1;
            end
            cmd.nbr_inc = 1'b1;
            state_in = stat.nbr_last ? S_OUT : S_NBR_RD;
         end
         S_CLR: begin
            cmd.sel = SEL_SWEEP;
            cmd.wr  = WR_ZERO;
            cmd.sweep_inc = 1'b1;
            if (stat.sweep_last) state_in = S_OUT;
         end
         S_OUT: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         act_ff    <= ACT_TOGGLE;
         status_ff <= ST_DONE;
         kind_ff   <= KIND_ZERO;
      end else begin
         state_ff  <= state_in;
         act_ff    <= act_in;
         status_ff <= status_in;
         kind_ff   <= kind_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ===== hw/rtl/gbs_dpath.sv =====
// ----------------------------------------------------------------------------
// gbs_dpath: datapath of the grid search stepper
// Cell store, cell queue, queue pointers, settings and result register.
// ----------------------------------------------------------------------------
module gbs_dpath import gbs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output stat_type         stat,
   input  logic [ROW_W-1:0] req_cell_row,
   input  logic [COL_W-1:0] req_cell_col,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [ROW_W-1:0] rsp_out_row,
   output logic [COL_W-1:0] rsp_out_col,
   output logic             rsp_is_obstacle,
   output logic             rsp_is_visited,
   output logic             rsp_in_frontier,
   output logic [2:0]       rsp_parent_dir,
   output logic             rsp_solved,
   output logic [CNT_W-1:0] rsp_queue_count
);

   logic [ROW_W-1:0]  start_row_ff, end_row_ff;
   logic [COL_W-1:0]  start_col_ff, end_col_ff;
   logic [CELL_W-1:0] req_ff, pop_ff, head_ff, sweep_ff;
   logic [CNT_W-1:0]  fill_ff;
   logic [1:0]        nbr_ff;
   logic              seeded_ff, solved_ff;
   logic [WORD_W-1:0] bits_ff, bits_in;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [CELL_W-1:0] rsp_cell_ff;
   logic [WORD_W-1:0] rsp_bits_ff;
   logic              rsp_solved_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   logic [CELL_W-1:0] cell_addr, nbr_addr, start_idx, q_waddr;
   logic [WORD_W-1:0] cell_rdata, cell_wdata;
   logic [CELL_W-1:0] q_rdata, q_wdata;
   logic              q_we, nbr_ok;
   logic [2:0]        nbr_dir;
   logic [ROW_W-1:0]  pr;
   logic [COL_W-1:0]  pc;

   assign start_idx = {start_row_ff, start_col_ff};
   assign pr = pop_ff[CELL_W-1:COL_W];
   assign pc = pop_ff[COL_W-1:0];

   // neighbours in order left, right, up, down; dir points back to the parent
   always_comb begin
      case (nbr_ff)
         2'd0: begin
            nbr_ok = (pc != '0); nbr_addr = {pr, pc - 1'b1}; nbr_dir = DIR_RIGHT;
         end
         2'd1: begin
            nbr_ok = (pc != COL_MAX); nbr_addr = {pr, pc + 1'b1}; nbr_dir = DIR_LEFT;
         end
         2'd2: begin
            nbr_ok = (pr != '0); nbr_addr = {pr - 1'b1, pc}; nbr_dir = DIR_DOWN;
         end
         default: begin
            nbr_ok = (pr != ROW_MAX); nbr_addr = {pr + 1'b1, pc}; nbr_dir = DIR_UP;
         end
      endcase
   end

   always_comb begin
      case (cmd.sel)
         SEL_PORT:  cell_addr = {req_cell_row, req_cell_col};
         SEL_REQ:   cell_addr = req_ff;
         SEL_START: cell_addr = start_idx;
         SEL_QDATA: cell_addr = q_rdata;
         SEL_POP:   cell_addr = pop_ff;
         SEL_NBR:   cell_addr = nbr_addr;
         SEL_SWEEP: cell_addr = sweep_ff;
         default:   cell_addr = req_ff;
      endcase
   end

   always_comb begin
      cell_wdata = '0;
      case (cmd.wr)
         WR_TOGGLE:  cell_wdata = cell_rdata ^ (WORD_W'(1) << BIT_OBST);
         WR_SEED:    cell_wdata = cell_rdata | (WORD_W'(1) << BIT_VIS)
                                             | (WORD_W'(1) << BIT_FRO);
         WR_UNFRONT: cell_wdata = cell_rdata & ~(WORD_W'(1) << BIT_FRO);
         WR_VISIT:   cell_wdata = {1'b0, 1'b1, 1'b1, nbr_dir};
         default:    cell_wdata = '0;
      endcase
   end

   gbs_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_cell_ram (
      .clock (clock),
      .we    (cmd.wr != WR_NONE),
      .waddr (cell_addr),
      .wdata (cell_wdata),
      .re    (cmd.cell_rd),
      .raddr (cell_addr),
      .rdata (cell_rdata)
   );

   assign q_we    = cmd.seed | cmd.push_nbr;
   assign q_waddr = cmd.seed ? '0 : head_ff + fill_ff[CELL_W-1:0];
   assign q_wdata = cmd.seed ? start_idx : nbr_addr;

   gbs_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_queue_ram (
      .clock (clock),
      .we    (q_we),
      .waddr (q_waddr),
      .wdata (q_wdata),
      .re    (cmd.q_rd),
      .raddr (head_ff),
      .rdata (q_rdata)
   );

   always_comb begin
      bits_in = bits_ff;
      if (cmd.cap_req_bits) begin
         bits_in = (cmd.wr == WR_TOGGLE) ? cell_wdata : cell_rdata;
      end else if (cmd.cap_pop_bits) begin
         bits_in = cell_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_row_ff <= '0;
         start_col_ff <= '0;
         end_row_ff   <= ROW_MAX;
         end_col_ff   <= COL_MAX;
         head_ff      <= '0;
         fill_ff      <= '0;
         seeded_ff    <= 1'b0;
         solved_ff    <= 1'b0;
         sweep_ff     <= '0;
         nbr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_START_ROW: start_row_ff <= csr_wdata[ROW_W-1:0];
               CSR_START_COL: start_col_ff <= csr_wdata[COL_W-1:0];
               CSR_END_ROW:   end_row_ff   <= csr_wdata[ROW_W-1:0];
               CSR_END_COL:   end_col_ff   <= csr_wdata[COL_W-1:0];
               default: ;
            endcase
         end
         if (cmd.wipe) begin
            head_ff   <= '0;
            fill_ff   <= '0;
            seeded_ff <= 1'b0;
            solved_ff <= 1'b0;
         end else if (cmd.seed) begin
            head_ff   <= '0;
            fill_ff   <= CNT_W'(1);
            seeded_ff <= 1'b1;
         end else if (cmd.pop) begin
            head_ff <= head_ff + 1'b1;
            fill_ff <= fill_ff - 1'b1;
         end else if (cmd.push_nbr) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (cmd.cap_pop_bits && pop_ff == {end_row_ff, end_col_ff}) begin
            solved_ff <= 1'b1;
         end
         if (cmd.sweep_clr) sweep_ff <= '0;
         else if (cmd.sweep_inc) sweep_ff <= sweep_ff + 1'b1;
         if (cmd.nbr_clr) nbr_ff <= '0;
         else if (cmd.nbr_inc) nbr_ff <= nbr_ff + 1'b1;
         if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
      if (cmd.load_req) req_ff <= {req_cell_row, req_cell_col};
      if (cmd.pop) pop_ff <= q_rdata;
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_solved_ff <= solved_ff;
         rsp_count_ff  <= fill_ff;
         case (cmd.rsp_kind)
            KIND_REQ: begin
               rsp_cell_ff <= req_ff;
               rsp_bits_ff <= bits_ff;
            end
            KIND_POP: begin
               rsp_cell_ff <= pop_ff;
               rsp_bits_ff <= bits_ff;
            end
            default: begin
               rsp_cell_ff <= '0;
               rsp_bits_ff <= '0;
            end
         endcase
      end
   end

   assign stat.solved     = solved_ff;
   assign stat.seeded     = seeded_ff;
   assign stat.fill_zero  = (fill_ff == '0);
   assign stat.sweep_last = (sweep_ff == {CELL_W{1'b1}});
   assign stat.nbr_ok     = nbr_ok;
   assign stat.nbr_last   = (nbr_ff == 2'd3);
   assign stat.nbr_free   = !cell_rdata[BIT_VIS] && !cell_rdata[BIT_OBST];
   assign stat.rsp_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_row     = rsp_cell_ff[CELL_W-1:COL_W];
   assign rsp_out_col     = rsp_cell_ff[COL_W-1:0];
   assign rsp_is_obstacle = rsp_bits_ff[BIT_OBST];
   assign rsp_is_visited  = rsp_bits_ff[BIT_VIS];
   assign rsp_in_frontier = rsp_bits_ff[BIT_FRO];
   assign rsp_parent_dir  = rsp_bits_ff[2:0];
   assign rsp_solved      = rsp_solved_ff;
   assign rsp_queue_count = rsp_count_ff;

endmodule

// ===== hw/rtl/grid_bfs_stepper.sv =====
// ----------------------------------------------------------------------------
// grid_bfs_stepper: stepwise breadth-first search on a 32 x 64 grid
//
//   channel | ports                         | role
//   req     | req_valid/req_stall, action,  | one grid action per item
//           | cell_row, cell_col            |
//   rsp     | rsp_valid/rsp_stall, fields   | one report per item
//   csr     | csr_write, csr_index, wdata   | start and end cell
//
// query and toggle read the cell and report; expand reports at once when
// solved, else reports an empty queue or pops a cell (one memory access per
// step on the single cell port: pop, then read and update of up to four
// neighbours, plus one to seed). clear sweeps all 2048 cells of cell memory.
// after reset the cell memory is swept, all 2048 cells, with req_stall high.
// a waiting report holds in the output register; the next item is taken
// while it waits and is finished up to its own report.
// ----------------------------------------------------------------------------
module grid_bfs_stepper import gbs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_action,
   input  logic [ROW_W-1:0] req_cell_row,
   input  logic [COL_W-1:0] req_cell_col,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [ROW_W-1:0] rsp_out_row,
   output logic [COL_W-1:0] rsp_out_col,
   output logic             rsp_is_obstacle,
   output logic             rsp_is_visited,
   output logic             rsp_in_frontier,
   output logic [2:0]       rsp_parent_dir,
   output logic             rsp_solved,
   output logic [CNT_W-1:0] rsp_queue_count,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   gbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   gbs_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_cell_row    (req_cell_row),
      .req_cell_col    (req_cell_col),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_is_obstacle (rsp_is_obstacle),
      .rsp_is_visited  (rsp_is_visited),
      .rsp_in_frontier (rsp_in_frontier),
      .rsp_parent_dir  (rsp_parent_dir),
      .rsp_solved      (rsp_solved),
      .rsp_queue_count (rsp_queue_count)
   );

endmodule

// ===== hw/rtl/gbs_checker.sv =====
// ----------------------------------------------------------------------------
// gbs_checker: port-level checks of the grid search stepper
// Watches the result channel and binds to the top level.
// ----------------------------------------------------------------------------
module gbs_checker import gbs_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [1:0]       rsp_status,
   input logic             rsp_is_visited,
   input logic [2:0]       rsp_parent_dir,
   input logic             rsp_solved,
   input logic [CNT_W-1:0] rsp_queue_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_DONE || rsp_status == ST_SOLVED ||
                     rsp_status == ST_EMPTY))
      else $error("bad status code");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_queue_count == '0)
      else $error("empty report with queued cells");

   a_parent_visited: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parent_dir != DIR_NONE |-> rsp_is_visited)
      else $error("cell with parent not visited");

   a_solved_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_SOLVED |-> rsp_solved)
      else $error("ignored item without solved flag");

endmodule

bind grid_bfs_stepper gbs_checker u_gbs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_is_visited  (rsp_is_visited),
   .rsp_parent_dir  (rsp_parent_dir),
   .rsp_solved      (rsp_solved),
   .rsp_queue_count (rsp_queue_count)
);

// ===== tb/sv/grid_bfs_stepper_tb.sv =====
// ----------------------------------------------------------------------------
// grid_bfs_stepper_tb: self-checking bench for the grid search stepper
// A directed table walks reset state, the grid extremes, the solved and
// empty-queue cases; random phases then set start and goal cells close
// together, lay obstacles and run searches to the goal. Every report is
// compared with its typed table row or a cycle-free software search in step.
// ----------------------------------------------------------------------------
module grid_bfs_stepper_tb import gbs_pkg::*; ();

   typedef struct packed {
      logic [1:0]       status;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             obst;
      logic             vis;
      logic             fro;
      logic [2:0]       dir;
      logic             solved;
      logic [CNT_W-1:0] count;
   } report_type;

   typedef struct packed {
      logic             cfg;
      logic             typed;
      logic [1:0]       act;
      logic [ROW_W-1:0] r;
      logic [COL_W-1:0] c;
      logic [ROW_W-1:0] er;
      logic [COL_W-1:0] ec;
      report_type       rep;
   } step_row_type;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_stall;
   logic [1:0]       req_action = ACT_QUERY;
   logic [ROW_W-1:0] req_cell_row = '0;
   logic [COL_W-1:0] req_cell_col = '0;
   logic             rsp_valid;
   logic             rsp_stall = 0;
   logic [1:0]       rsp_status;
   logic [ROW_W-1:0] rsp_out_row;
   logic [COL_W-1:0] rsp_out_col;
   logic             rsp_is_obstacle, rsp_is_visited, rsp_in_frontier;
   logic [2:0]       rsp_parent_dir;
   logic             rsp_solved;
   logic [CNT_W-1:0] rsp_queue_count;
   logic             csr_write = 0;
   logic [1:0]       csr_index = CSR_START_ROW;
   logic [CSR_W-1:0] csr_wdata = '0;

   grid_bfs_stepper uut (.*);

   always #5 clock = ~clock;

   // software copy of the grid and search state
   bit               obst_map[CELLS], vis_map[CELLS], fro_map[CELLS];
   logic [2:0]       dir_map[CELLS];
   logic [CELL_W-1:0] bfs_queue[CELLS];
   int               q_head, q_fill;
   bit               seeded, solved;
   logic [ROW_W-1:0] start_r, goal_r;
   logic [COL_W-1:0] start_c, goal_c;

   report_type       pending_reports[$];
   int               errors = 0;
   bit               no_gaps = 0;
   int               items_sent = 0;

   task automatic wipe_grid();
      for (int i = 0; i < CELLS; i++) begin
         obst_map[i] = 1'b0; vis_map[i] = 1'b0; fro_map[i] = 1'b0; dir_map[i] = DIR_NONE;
      end
      q_head = 0; q_fill = 0; seeded = 1'b0; solved = 1'b0;
   endtask

   task automatic enqueue_free(input int idx, input logic [2:0] dir);
      if (!vis_map[idx] && !obst_map[idx]) begin
         dir_map[idx] = dir; vis_map[idx] = 1'b1; fro_map[idx] = 1'b1;
         bfs_queue[(q_head + q_fill) % CELLS] = CELL_W'(idx);
         q_fill++;
      end
   endtask

   function automatic report_type cell_report(input logic [1:0] st, input int r,
                                              input int c);
      report_type o;
      int idx;
      idx = r * 64 + c;
      o = '0;
      o.status = st; o.row = ROW_W'(r); o.col = COL_W'(c);
      o.obst = obst_map[idx]; o.vis = vis_map[idx]; o.fro = fro_map[idx];
      o.dir = dir_map[idx];
      return o;
   endfunction

   // advance the search by one item and return its report
   task automatic search_step(input logic [1:0] act, input int r, input int c,
                              output report_type o);
      int idx, pr, pc;
      o = '0;
      case (act)
         ACT_TOGGLE: begin
            if (!solved) obst_map[r * 64 + c] ^= 1'b1;
            o = cell_report(solved ? ST_SOLVED : ST_DONE, r, c);
         end
         ACT_CLEAR: wipe_grid();
         ACT_EXPAND: begin
            if (solved) begin
               o.status = ST_SOLVED;
            end else begin
               if (!seeded) begin
                  seeded = 1'b1; q_head = 0; q_fill = 0;
                  idx = start_r * 64 + start_c;
                  vis_map[idx] = 1'b1; fro_map[idx] = 1'b1;
                  bfs_queue[0] = CELL_W'(idx); q_fill = 1;
               end
               if (q_fill == 0) begin
                  o.status = ST_EMPTY;
               end else begin
                  idx = int'(bfs_queue[q_head]);
                  pr = idx / 64; pc = idx % 64;
                  q_head = (q_head + 1) % CELLS; q_fill--;
                  fro_map[idx] = 1'b0;
                  if (pr == goal_r && pc == goal_c) solved = 1'b1;
                  if (pc > 0) enqueue_free(idx - 1, DIR_RIGHT);
                  if (pc < 63) enqueue_free(idx + 1, DIR_LEFT);
                  if (pr > 0) enqueue_free(idx - 64, DIR_DOWN);
                  if (pr < 31) enqueue_free(idx + 64, DIR_UP);
                  o = cell_report(ST_DONE, pr, pc);
               end
            end
         end
         default: o = cell_report(ST_DONE, r, c);
      endcase
      o.solved = solved;
      o.count = CNT_W'(q_fill);
   endtask

   task automatic send_item(input logic [1:0] act, input int r, input int c,
                            input bit typed, input report_type typed_rep);
      report_type o;
      int gap;
      req_valid <= 1'b1; req_action <= act;
      req_cell_row <= ROW_W'(r); req_cell_col <= COL_W'(c);
      do @(posedge clock); while (req_stall);
      search_step(act, r, c, o);
      pending_reports.push_back(typed ? typed_rep : o);
      items_sent++;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // registers change only with the block idle
   task automatic set_cells(input int sr, input int sc, input int er, input int ec);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_write <= 1'b1; csr_index <= CSR_START_ROW; csr_wdata <= CSR_W'(sr);
      @(posedge clock);
      csr_index <= CSR_START_COL; csr_wdata <= CSR_W'(sc); @(posedge clock);
      csr_index <= CSR_END_ROW; csr_wdata <= CSR_W'(er); @(posedge clock);
      csr_index <= CSR_END_COL; csr_wdata <= CSR_W'(ec); @(posedge clock);
      csr_write <= 1'b0;
      start_r = ROW_W'(sr); start_c = COL_W'(sc);
      goal_r = ROW_W'(er); goal_c = COL_W'(ec);
   endtask

   function automatic int near(input int v, input int hi);
      int x;
      x = v + $urandom_range(0, 6) - 3;
      return x < 0 ? 0 : (x > hi ? hi : x);
   endfunction

   // result side: random stall and compare
   int rsp_hold = 0;
   always @(posedge clock) begin
      report_type got, want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_out_row, rsp_out_col, rsp_is_obstacle, rsp_is_visited,
                    rsp_in_frontier, rsp_parent_dir, rsp_solved, rsp_queue_count};
            if (pending_reports.size() == 0) begin
               $error("unexpected report %p", got);
               errors++;
            end else begin
               want = pending_reports.pop_front();
               if (got.status !== want.status) begin
                  $error("status exp %0d got %0d", want.status, got.status); errors++; end
               if (got.row !== want.row) begin
                  $error("out_row exp %0d got %0d", want.row, got.row); errors++; end
               if (got.col !== want.col) begin
                  $error("out_col exp %0d got %0d", want.col, got.col); errors++; end
               if (got.obst !== want.obst) begin
                  $error("is_obstacle exp %0d got %0d", want.obst, got.obst); errors++; end
               if (got.vis !== want.vis) begin
                  $error("is_visited exp %0d got %0d", want.vis, got.vis); errors++; end
               if (got.fro !== want.fro) begin
                  $error("in_frontier exp %0d got %0d", want.fro, got.fro); errors++; end
               if (got.dir !== want.dir) begin
                  $error("parent_dir exp %0d got %0d", want.dir, got.dir); errors++; end
               if (got.solved !== want.solved) begin
                  $error("solved exp %0d got %0d", want.solved, got.solved); errors++; end
               if (got.count !== want.count) begin
                  $error("queue_count exp %0d got %0d", want.count, got.count); errors++; end
            end
            rsp_hold = no_gaps ? 0 : $urandom_range(0, 8);
         end
         rsp_stall <= (rsp_hold > 0);
         if (rsp_hold > 0) rsp_hold--;
      end
   end

   step_row_type directed[] = '{
      '{0, 1, ACT_QUERY,  0,  0, 0, 0, '{ST_DONE, 0, 0, 0, 0, 0, DIR_NONE, 0, 0}},
      '{0, 1, ACT_QUERY, 31, 63, 0, 0, '{ST_DONE, 31, 63, 0, 0, 0, DIR_NONE, 0, 0}},
      '{0, 1, ACT_TOGGLE, 0,  1, 0, 0, '{ST_DONE, 0, 1, 1, 0, 0, DIR_NONE, 0, 0}},
      '{0, 1, ACT_TOGGLE,31, 63, 0, 0, '{ST_DONE, 31, 63, 1, 0, 0, DIR_NONE, 0, 0}},
      '{0, 1, ACT_TOGGLE,31, 63, 0, 0, '{ST_DONE, 31, 63, 0, 0, 0, DIR_NONE, 0, 0}},
      '{0, 1, ACT_EXPAND, 0,  0, 0, 0, '{ST_DONE, 0, 0, 0, 1, 0, DIR_NONE, 0, 1}},
      '{0, 1, ACT_QUERY,  1,  0, 0, 0, '{ST_DONE, 1, 0, 0, 1, 1, DIR_UP, 0, 1}},
      '{0, 0, ACT_EXPAND, 0,  0, 0, 0, '0},
      '{0, 0, ACT_QUERY,  0,  1, 0, 0, '0},
      '{0, 1, ACT_CLEAR,  7,  9, 0, 0, '{ST_DONE, 0, 0, 0, 0, 0, DIR_NONE, 0, 0}},
      '{0, 0, ACT_EXPAND, 0,  0, 0, 0, '0},
      // start on the goal in the far corner
      '{1, 0, ACT_QUERY, 31, 63, 31, 63, '0},
      '{0, 1, ACT_CLEAR,  0,  0, 0, 0, '{ST_DONE, 0, 0, 0, 0, 0, DIR_NONE, 0, 0}},
      '{0, 1, ACT_TOGGLE,31, 62, 0, 0, '{ST_DONE, 31, 62, 1, 0, 0, DIR_NONE, 0, 0}},
      '{0, 1, ACT_EXPAND, 0,  0, 0, 0, '{ST_DONE, 31, 63, 0, 1, 0, DIR_NONE, 1, 1}},
      '{0, 1, ACT_EXPAND, 0,  0, 0, 0, '{ST_SOLVED, 0, 0, 0, 0, 0, DIR_NONE, 1, 1}},
      '{0, 1, ACT_TOGGLE, 5,  5, 0, 0, '{ST_SOLVED, 5, 5, 0, 0, 0, DIR_NONE, 1, 1}},
      '{0, 1, ACT_QUERY, 30, 63, 0, 0, '{ST_DONE, 30, 63, 0, 1, 1, DIR_DOWN, 1, 1}},
      // walled-in start runs the queue dry
      '{1, 0, ACT_QUERY,  0,  0, 31, 0, '0},
      '{0, 0, ACT_CLEAR,  0,  0, 0, 0, '0},
      '{0, 1, ACT_TOGGLE, 0,  1, 0, 0, '{ST_DONE, 0, 1, 1, 0, 0, DIR_NONE, 0, 0}},
      '{0, 0, ACT_TOGGLE, 1,  0, 0, 0, '0},
      '{0, 0, ACT_EXPAND, 0,  0, 0, 0, '0},
      '{0, 1, ACT_EXPAND, 0,  0, 0, 0, '{ST_EMPTY, 0, 0, 0, 0, 0, DIR_NONE, 0, 0}}
   };

   initial begin
      int sr, sc, er, ec, n;
      wipe_grid();
      start_r = '0; start_c = '0; goal_r = ROW_MAX; goal_c = COL_MAX;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i]) begin
         if (directed[i].cfg)
            set_cells(directed[i].r, directed[i].c, directed[i].er, directed[i].ec);
         else
            send_item(directed[i].act, directed[i].r, directed[i].c,
                      directed[i].typed, directed[i].rep);
      end
      while (items_sent < 420) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 5))
            0: begin sr = 0; sc = 0; er = 0; ec = 2; end
            1: begin sr = ROW_MAX; sc = COL_MAX; er = 29; ec = 63; end
            default: begin
               sr = $urandom_range(0, 31); sc = $urandom_range(0, 63);
               er = near(sr, 31); ec = near(sc, 63);
            end
         endcase
         // sender holds off until the block has drained
         set_cells(sr, sc, er, ec);
         send_item(ACT_CLEAR, $urandom_range(0, 31), $urandom_range(0, 63), 0, '0);
         n = $urandom_range(2, 8);
         repeat (n) send_item(ACT_TOGGLE, near(sr, 31), near(sc, 63), 0, '0);
         n = $urandom_range(15, 45);
         repeat (n) begin
            case ($urandom_range(0, 9))
               0: send_item(ACT_QUERY, $urandom_range(0, 31), $urandom_range(0, 63), 0, '0);
               1, 2: send_item(ACT_QUERY, near(sr, 31), near(sc, 63), 0, '0);
               3: send_item(ACT_TOGGLE, near(er, 31), near(ec, 63), 0, '0);
               4: send_item(ACT_TOGGLE, $urandom_range(0, 31), $urandom_range(0, 63), 0, '0);
               default: send_item(ACT_EXPAND, $urandom_range(0, 31),
                                  $urandom_range(0, 63), 0, '0);
            endcase
         end
      end
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (errors == 0 && pending_reports.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== grid_bfs_stepper.f =====
hw/rtl/gbs_pkg.sv
hw/rtl/gbs_ram.sv
hw/rtl/gbs_ctrl.sv
hw/rtl/gbs_dpath.sv
hw/rtl/grid_bfs_stepper.sv
hw/rtl/gbs_checker.sv
tb/sv/grid_bfs_stepper_tb.sv
